>>> rtl/pcfb_pkg.sv
// ---------------------------------------------------------------------------
// pcfb_pkg
// shared types and constants of the pulse count frame builder
// ---------------------------------------------------------------------------
package pcfb_pkg;

	localparam int FRAME_ITEMS_DEF = 64;

	localparam logic [14:0] HALF_MAX     = 15'h7FFF;
	localparam logic [7:0]  DEFAULT_STEP = 8'd5;

	// register indexes of the configuration port
	localparam logic [2:0] REG_OFF_CODE   = 3'd0;
	localparam logic [2:0] REG_MIN_TEMP   = 3'd1;
	localparam logic [2:0] REG_MAX_TEMP   = 3'd2;
	localparam logic [2:0] REG_TEMP_STEP  = 3'd3;
	localparam logic [2:0] REG_SYNC_LOW   = 3'd4;
	localparam logic [2:0] REG_PULSE_HIGH = 3'd5;
	localparam logic [2:0] REG_PULSE_LOW  = 3'd6;

	typedef struct packed {
		logic [7:0]  off_code;
		logic [7:0]  min_temp;
		logic [7:0]  max_temp;
		logic [7:0]  temp_step;
		logic [19:0] sync_low_ticks;
		logic [14:0] pulse_high_ticks;
		logic [14:0] pulse_low_ticks;
	} cfg_t;

	typedef struct packed {
		logic [14:0] second_duration;
		logic        second_level;
		logic [14:0] first_duration;
		logic        first_level;
	} item_t;

endpackage

>>> rtl/pulse_count_frame_builder_unit.sv
// ---------------------------------------------------------------------------
// pulse_count_frame_builder_unit
// turns heater commands into frames of pulse-count waveform items
// ---------------------------------------------------------------------------
// each command request (off flag in tuser, signed target in sixteenths of a
// degree in tdata) becomes one frame on the master side: sync-low items of
// up to two 32767-tick halves, one high/low item per pulse of the code, and
// an all-zero item flagged tlast; a frame holds at most FRAME_ITEMS items with
// the end marker. the front runs a heat request through a 9-step restoring
// divider, takes an off request straight to its push state, then drops the
// code into a two-entry queue; the back sends one item per cycle from its
// output register while the master side is ready, emits no item as it pops
// the code or at either phase change, and takes the next code only once the
// end marker has entered its output register. the user must write registers
// via cfg_we/cfg_index/cfg_data only while idle; the block does not check.
module pulse_count_frame_builder_unit #(
	parameter int FRAME_ITEMS = pcfb_pkg::FRAME_ITEMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	// command requests
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [13:0] target_temp_q4, [15:14] zero
	input  logic [0:0]  s_axis_tuser,   // [0] mode_off
	// waveform items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [0] first_level, [15:1] first_duration,
	                                    // [16] second_level, [31:17] second_duration
	output logic        m_axis_tlast    // last_item
);

	pcfb_pkg::cfg_t  cfg_q;
	pcfb_pkg::item_t item;

	logic       push;
	logic       full;
	logic [7:0] code_in;
	logic       pop;
	logic       code_valid;
	logic [7:0] code_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off_code         <= 8'd0;
			cfg_q.min_temp         <= 8'd0;
			cfg_q.max_temp         <= 8'd255;
			cfg_q.temp_step        <= 8'd5;
			cfg_q.sync_low_ticks   <= 20'd120000;
			cfg_q.pulse_high_ticks <= 15'd2000;
			cfg_q.pulse_low_ticks  <= 15'd2000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcfb_pkg::REG_OFF_CODE:   cfg_q.off_code         <= cfg_data[7:0];
				pcfb_pkg::REG_MIN_TEMP:   cfg_q.min_temp         <= cfg_data[7:0];
				pcfb_pkg::REG_MAX_TEMP:   cfg_q.max_temp         <= cfg_data[7:0];
				pcfb_pkg::REG_TEMP_STEP:  cfg_q.temp_step        <= cfg_data[7:0];
				pcfb_pkg::REG_SYNC_LOW:   cfg_q.sync_low_ticks   <= cfg_data;
				pcfb_pkg::REG_PULSE_HIGH: cfg_q.pulse_high_ticks <= cfg_data[14:0];
				pcfb_pkg::REG_PULSE_LOW:  cfg_q.pulse_low_ticks  <= cfg_data[14:0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// front: command to pulse code
	pcfb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd_valid      (s_axis_tvalid),
		.cmd_ready      (s_axis_tready),
		.mode_off       (s_axis_tuser[0]),
		.target_temp_q4 ($signed(s_axis_tdata[13:0])),
		.push           (push),
		.full           (full),
		.code           (code_in)
	);

	// code queue, lets the front run ahead of a long frame
	pcfb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (code_in),
		.full   (full),
		.pop    (pop),
		.valid  (code_valid),
		.rdata  (code_out)
	);

	// back: code to frame of items
	pcfb_back #(
		.FRAME_ITEMS (FRAME_ITEMS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.code_valid (code_valid),
		.code       (code_out),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_item   (item),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = item;

`ifndef SYNTH
	// the end marker carries no waveform
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 32'd0)
		else $error("end marker with nonzero payload");

	// the front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("code queue overflow");

	// the front never takes two command requests back to back
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("front took two requests back to back");

	// the back only pops a code it can see
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> code_valid)
		else $error("pop from empty code queue");
`endif

endmodule

>>> rtl/pcfb_front.sv
// ---------------------------------------------------------------------------
// pcfb_front
// takes commands and turns them into 8-bit pulse codes
// ---------------------------------------------------------------------------
module pcfb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  pcfb_pkg::cfg_t    cfg,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic              mode_off,
	input  logic signed [13:0] target_temp_q4,
	output logic              push,
	input  logic              full,
	output logic [7:0]        code
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]  state_q;
	logic [3:0]  cnt_q;
	logic [8:0]  num_q;
	logic [7:0]  rem_q;
	logic [7:0]  step_q;
	logic        neg_q;
	logic        off_q;

	logic [7:0]         step_eff;
	logic [13:0]        mag;
	logic [14:0]        mag_rnd;
	logic signed [10:0] deg;
	logic signed [10:0] deg_lo;
	logic signed [10:0] deg_c;
	logic signed [10:0] lo_s;
	logic signed [10:0] hi_s;
	logic signed [10:0] numer;
	logic [10:0]        numer_abs;
	logic [8:0]         trial;
	logic               fits;
	logic [16:0]        prod;
	logic [7:0]         prod_s;

	assign cmd_ready = (state_q == F_IDLE);
	assign step_eff  = (cfg.temp_step == 8'd0) ? pcfb_pkg::DEFAULT_STEP : cfg.temp_step;

	// round half away from zero to whole degrees, then clamp and form the numerator
	always_comb begin
		mag     = target_temp_q4[13] ? 14'(-target_temp_q4) : 14'(target_temp_q4);
		mag_rnd = {1'b0, mag} + 15'd8;
		deg     = target_temp_q4[13] ? -$signed({1'b0, mag_rnd[13:4]})
		                             :  $signed({1'b0, mag_rnd[13:4]});
		lo_s    = $signed({3'b000, cfg.min_temp});
		hi_s    = $signed({3'b000, cfg.max_temp});
		deg_lo  = (deg < lo_s) ? lo_s : deg;
		deg_c   = (deg_lo > hi_s) ? hi_s : deg_lo;
		numer   = deg_c - lo_s + $signed({4'b0000, step_eff[7:1]});
		numer_abs = numer[10] ? 11'(-numer) : 11'(numer);
	end

	// one restoring divider step
	always_comb begin
		trial = {rem_q, num_q[8]};
		fits  = (trial >= {1'b0, step_q});
	end

	always_comb begin
		prod   = num_q * step_q;
		prod_s = neg_q ? 8'(-prod[7:0]) : prod[7:0];
		code   = off_q ? rem_q : 8'(cfg.min_temp + prod_s);
	end

	assign push = (state_q == F_PUSH) && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (cmd_valid) begin
						cnt_q   <= 4'd9;
						state_q <= mode_off ? F_PUSH : F_DIV;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd1) state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath: rem_q doubles as the stored off code
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && cmd_valid) begin
			off_q  <= mode_off;
			step_q <= step_eff;
			neg_q  <= numer[10];
			num_q  <= numer_abs[8:0];
			rem_q  <= mode_off ? cfg.off_code : 8'd0;
		end else if (state_q == F_DIV) begin
			rem_q <= fits ? 8'(trial - {1'b0, step_q}) : trial[7:0];
			num_q <= {num_q[7:0], fits};
		end
	end

endmodule

>>> rtl/pcfb_fifo.sv
// ---------------------------------------------------------------------------
// pcfb_fifo
// two-entry code queue between front and back
// ---------------------------------------------------------------------------
module pcfb_fifo (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] wdata,
	output logic       full,
	input  logic       pop,
	output logic       valid,
	output logic [7:0] rdata
);

	logic [7:0] mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

endmodule

>>> rtl/pcfb_back.sv
// ---------------------------------------------------------------------------
// pcfb_back
// expands one pulse code into a frame of waveform items
// ---------------------------------------------------------------------------
module pcfb_back #(
	parameter int FRAME_ITEMS = pcfb_pkg::FRAME_ITEMS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pcfb_pkg::cfg_t  cfg,
	input  logic            code_valid,
	input  logic [7:0]      code,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output pcfb_pkg::item_t out_item,
	output logic            out_last
);

	localparam int CNT_W = (FRAME_ITEMS > 2) ? $clog2(FRAME_ITEMS) : 1;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(FRAME_ITEMS - 1);

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_SYNC  = 2'd1;
	localparam logic [1:0] B_PULSE = 2'd2;
	localparam logic [1:0] B_END   = 2'd3;

	logic [1:0]       state_q;
	logic [19:0]      sync_left_q;
	logic [7:0]       pulses_left_q;
	logic [CNT_W-1:0] n_q;
	logic             out_valid_q;
	logic             last_q;
	pcfb_pkg::item_t  item_q;

	logic        room;
	logic        at_cap;
	logic        sync_done;
	logic        pulse_done;
	logic        emit;
	logic [14:0] d0;
	logic [19:0] r1;
	logic [14:0] d1;

	assign room       = !out_valid_q || out_ready;
	assign at_cap     = (n_q == CAP);
	assign sync_done  = (sync_left_q == 20'd0) || at_cap;
	assign pulse_done = (pulses_left_q == 8'd0) || at_cap;
	assign pop        = (state_q == B_IDLE) && code_valid;
	assign out_valid  = out_valid_q;
	assign out_item   = item_q;
	assign out_last   = last_q;

	always_comb begin
		d0 = (sync_left_q > {5'd0, pcfb_pkg::HALF_MAX}) ? pcfb_pkg::HALF_MAX : sync_left_q[14:0];
		r1 = sync_left_q - {5'd0, d0};
		d1 = (r1 > {5'd0, pcfb_pkg::HALF_MAX}) ? pcfb_pkg::HALF_MAX : r1[14:0];
	end

	// a new item enters the output register this cycle
	always_comb begin
		unique case (state_q)
			B_SYNC:  emit = room && !sync_done;
			B_PULSE: emit = room && !pulse_done;
			B_END:   emit = room;
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			sync_left_q   <= '0;
			pulses_left_q <= '0;
			n_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !out_ready);
			unique case (state_q)
				B_IDLE: begin
					if (code_valid) begin
						sync_left_q   <= cfg.sync_low_ticks;
						pulses_left_q <= code;
						n_q           <= '0;
						state_q       <= B_SYNC;
					end
				end
				B_SYNC: begin
					if (room) begin
						if (sync_done) begin
							state_q <= B_PULSE;
						end else begin
							sync_left_q <= r1 - {5'd0, d1};
							n_q         <= n_q + CNT_W'(1);
						end
					end
				end
				B_PULSE: begin
					if (room) begin
						if (pulse_done) begin
							state_q <= B_END;
						end else begin
							pulses_left_q <= pulses_left_q - 8'd1;
							n_q           <= n_q + CNT_W'(1);
						end
					end
				end
				B_END: begin
					if (room) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (room) begin
			if (state_q == B_SYNC) begin
				item_q.first_level     <= 1'b0;
				item_q.first_duration  <= d0;
				item_q.second_level    <= 1'b0;
				item_q.second_duration <= d1;
				last_q                 <= 1'b0;
			end else if (state_q == B_PULSE) begin
				item_q.first_level     <= 1'b1;
				item_q.first_duration  <= cfg.pulse_high_ticks;
				item_q.second_level    <= 1'b0;
				item_q.second_duration <= cfg.pulse_low_ticks;
				last_q                 <= 1'b0;
			end else if (state_q == B_END) begin
				item_q <= '0;
				last_q <= 1'b1;
			end
		end
	end

endmodule

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the pulse count frame builder: every command
// request is turned into its expected frame of waveform words by a local
// predictor, and each word leaving the block is checked field by field
// against the oldest word still pending
// ---------------------------------------------------------------------------
module tb_top;
	import pcfb_pkg::*;

	localparam int FRAME_MAX = FRAME_ITEMS_DEF;
	localparam int IDLE_TAIL = 24;            // covers the front end latency
	localparam int REPORT_MAX = 10;

	// register index the block does not decode
	localparam logic [2:0] REG_NONE = 3'd7;

	// register values right after reset
	localparam cfg_t CFG_RESET = {8'd0, 8'd0, 8'd255, 8'd5, 20'd120000, 15'd2000, 15'd2000};

	// one expected waveform word with its end-of-frame flag
	typedef struct packed {
		logic  last;
		item_t word;
	} frame_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // [13:0] target_temp_q4, [15:14] zero
	logic [0:0]  s_axis_tuser = '0;   // [0] mode_off
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [0] first_level, [15:1] first_duration,
	                                  // [16] second_level, [31:17] second_duration
	logic        m_axis_tlast;        // last_item

	// mirror of the register file, words still to arrive and run statistics
	cfg_t        regs_now = CFG_RESET;
	frame_word_t pending_words[$];
	int          bad_count = 0;
	int          words_seen = 0;
	int          cmds_sent = 0;
	int          capped_frames = 0;
	int          settings_used = 0;
	int          off_cmds = 0;
	bit          no_gaps = 1'b0;     // both sides run back to back while set
	int          rx_hold = 0;

	pulse_count_frame_builder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#40000000;
		$display("tb_top: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// pulse count for one command under the current register values
	function automatic logic [7:0] heat_code(logic off, logic [13:0] raw);
		int v, deg, lo, hi, st, q;
		if (off)
			return regs_now.off_code;
		v = int'($signed(raw));
		// round to whole degrees, halves away from zero
		if (v >= 0)
			deg = (v + 8) / 16;
		else
			deg = -((-v + 8) / 16);
		lo = int'(regs_now.min_temp);
		hi = int'(regs_now.max_temp);
		// floor first, then ceiling: a floor above the ceiling ends at the ceiling
		if (deg < lo)
			deg = lo;
		if (deg > hi)
			deg = hi;
		st = (regs_now.temp_step != '0) ? int'(regs_now.temp_step) : int'(DEFAULT_STEP);
		// signed division truncates toward zero, the code wraps to 8 bits
		q = lo + (((deg - lo) + st / 2) / st) * st;
		return q[7:0];
	endfunction

	// queue up the whole frame that one accepted command must produce
	function automatic void predict_frame(logic off, logic [13:0] raw);
		int n, sync_rest, d0, d1, pulses;
		frame_word_t w;
		pulses = heat_code(off, raw);
		sync_rest = int'(regs_now.sync_low_ticks);
		n = 0;
		// sync-low words, two halves of at most HALF_MAX ticks each
		while (sync_rest > 0 && n < FRAME_MAX - 1) begin
			d0 = (sync_rest > int'(HALF_MAX)) ? int'(HALF_MAX) : sync_rest;
			sync_rest -= d0;
			d1 = (sync_rest > int'(HALF_MAX)) ? int'(HALF_MAX) : sync_rest;
			sync_rest -= d1;
			w = '0;
			w.word.first_duration = d0[14:0];
			w.word.second_duration = d1[14:0];
			pending_words.push_back(w);
			n++;
		end
		// one high/low word per pulse, until the frame is full
		while (pulses > 0 && n < FRAME_MAX - 1) begin
			w = '0;
			w.word.first_level = 1'b1;
			w.word.first_duration = regs_now.pulse_high_ticks;
			w.word.second_duration = regs_now.pulse_low_ticks;
			pending_words.push_back(w);
			pulses--;
			n++;
		end
		if (sync_rest > 0 || pulses > 0)
			capped_frames++;
		// all-zero end marker
		w = '0;
		w.last = 1'b1;
		pending_words.push_back(w);
	endfunction

	// register write as the block sees it; unknown indexes change nothing
	function automatic void mirror_write(logic [2:0] idx, logic [19:0] d);
		case (idx)
			REG_OFF_CODE:   regs_now.off_code = d[7:0];
			REG_MIN_TEMP:   regs_now.min_temp = d[7:0];
			REG_MAX_TEMP:   regs_now.max_temp = d[7:0];
			REG_TEMP_STEP:  regs_now.temp_step = d[7:0];
			REG_SYNC_LOW:   regs_now.sync_low_ticks = d;
			REG_PULSE_HIGH: regs_now.pulse_high_ticks = d[14:0];
			REG_PULSE_LOW:  regs_now.pulse_low_ticks = d[14:0];
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// result side: random stalls and the word checker
	// ------------------------------------------------------------------

	// a fresh stall length is drawn after every accepted word
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			rx_hold = no_gaps ? 0 : $urandom_range(0, 7);
		else if (rx_hold > 0)
			rx_hold = rx_hold - 1;
		m_axis_tready <= (rx_hold == 0);
	end

	always @(posedge clk) begin
		item_t       got;
		frame_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = item_t'(m_axis_tdata);
			if (pending_words.size() == 0) begin
				bad_count++;
				if (bad_count <= REPORT_MAX)
					$display("word %0d, nothing pending: %b/%0d %b/%0d last %b",
						words_seen, got.first_level, got.first_duration,
						got.second_level, got.second_duration, m_axis_tlast);
			end else begin
				want = pending_words.pop_front();
				if (got.first_level !== want.word.first_level ||
				    got.first_duration !== want.word.first_duration ||
				    got.second_level !== want.word.second_level ||
				    got.second_duration !== want.word.second_duration ||
				    m_axis_tlast !== want.last) begin
					bad_count++;
					if (bad_count <= REPORT_MAX)
						$display("word %0d: want %b/%0d %b/%0d %b, got %b/%0d %b/%0d %b",
							words_seen, want.word.first_level, want.word.first_duration,
							want.word.second_level, want.word.second_duration, want.last,
							got.first_level, got.first_duration,
							got.second_level, got.second_duration, m_axis_tlast);
				end
			end
			words_seen++;
		end
	end

	// ------------------------------------------------------------------
	// command side
	// ------------------------------------------------------------------

	// one command request; valid stays high into the next call when no gap is drawn
	task automatic send_cmd(input logic off, input logic [13:0] raw);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, raw};
		s_axis_tuser <= off;
		do @(posedge clk); while (!s_axis_tready);
		predict_frame(off, raw);
		cmds_sent++;
		if (off)
			off_cmds++;
	endtask

	// hold off new requests until every pending word is out and the front is empty
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	// write all seven registers; with junk set the unused upper data bits are
	// random and the undecoded index gets a write too
	task automatic load_cfg(input cfg_t c, input bit junk);
		logic [19:0] d;
		logic [2:0]  idx;
		for (int i = 0; i <= (junk ? int'(REG_NONE) : int'(REG_PULSE_LOW)); i++) begin
			idx = i[2:0];
			d = junk ? 20'($urandom) : '0;
			case (idx)
				REG_OFF_CODE:   d[7:0] = c.off_code;
				REG_MIN_TEMP:   d[7:0] = c.min_temp;
				REG_MAX_TEMP:   d[7:0] = c.max_temp;
				REG_TEMP_STEP:  d[7:0] = c.temp_step;
				REG_SYNC_LOW:   d = c.sync_low_ticks;
				REG_PULSE_HIGH: d[14:0] = c.pulse_high_ticks;
				REG_PULSE_LOW:  d[14:0] = c.pulse_low_ticks;
				default: ;
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= d;
			mirror_write(idx, d);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [19:0] extreme_or_any(int unsigned top);
		case ($urandom_range(0, 3))
			0: return '0;
			1: return top[19:0];
			default: return 20'($urandom_range(0, top));
		endcase
	endfunction

	// random setting, biased toward useful temperature windows and short sync
	function automatic cfg_t rand_cfg();
		cfg_t c;
		c.off_code = 8'(extreme_or_any(255));
		c.min_temp = ($urandom_range(0, 2) == 0) ? 8'(extreme_or_any(255))
		                                         : 8'($urandom_range(0, 60));
		c.max_temp = ($urandom_range(0, 2) == 0) ? 8'(extreme_or_any(255))
		                                         : 8'($urandom_range(60, 255));
		c.temp_step = $urandom_range(0, 1) ? 8'(extreme_or_any(255))
		                                   : 8'($urandom_range(0, 12));
		c.sync_low_ticks = ($urandom_range(0, 3) == 0) ? extreme_or_any(20'hFFFFF)
		                                               : 20'($urandom_range(0, 140000));
		c.pulse_high_ticks = 15'(extreme_or_any(32767));
		c.pulse_low_ticks = 15'(extreme_or_any(32767));
		return c;
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// register values straight out of reset, field extremes and rounding halves
	task automatic test_defaults();
		send_cmd(1'b1, 14'd0);       // off code 0: sync words and the marker only
		send_cmd(1'b0, 14'h1FFF);    // hottest target, clamped to the ceiling
		send_cmd(1'b0, 14'h2000);    // coldest target, clamped to the floor
		send_cmd(1'b0, 14'd8);       // exactly half a degree rounds up
		send_cmd(1'b0, 14'd39);      // just under a half rounds down
		send_cmd(1'b0, 14'd40);      // 2.5 degrees goes to 3, quantized to 5
	endtask

	// no sync period, step of zero, widest pulses: pulse words hit the cap
	task automatic test_pulse_cap();
		cfg_t c;
		c = CFG_RESET;
		c.off_code = 8'd255;
		c.temp_step = 8'd0;
		c.sync_low_ticks = 20'd0;
		c.pulse_high_ticks = 15'h7FFF;
		c.pulse_low_ticks = 15'd0;
		wait_idle();
		load_cfg(c, 1'b0);
		send_cmd(1'b1, 14'h3FFF);
		send_cmd(1'b0, 14'h1FFF);
		send_cmd(1'b0, 14'd0);       // code 0 and no sync: marker alone
	endtask

	// longest sync period: sync words take seventeen items of the frame
	task automatic test_sync_cap();
		cfg_t c;
		c = CFG_RESET;
		c.off_code = 8'd1;
		c.sync_low_ticks = 20'hFFFFF;
		c.pulse_high_ticks = 15'd0;
		c.pulse_low_ticks = 15'h7FFF;
		wait_idle();
		load_cfg(c, 1'b1);
		send_cmd(1'b1, 14'd0);
		send_cmd(1'b0, 14'd1600);
	endtask

	// floor above ceiling, with a coarse step and with a unit step
	task automatic test_min_above_max();
		cfg_t c;
		c = CFG_RESET;
		c.min_temp = 8'd250;
		c.max_temp = 8'd0;
		c.temp_step = 8'd255;
		c.sync_low_ticks = 20'd32768;
		wait_idle();
		load_cfg(c, 1'b0);
		send_cmd(1'b0, 14'd1600);
		c.temp_step = 8'd1;
		wait_idle();
		load_cfg(c, 1'b0);
		send_cmd(1'b0, 14'd1600);
	endtask

	// quantizing past 255 wraps the code; junk in the unused data bits
	task automatic test_code_wrap();
		cfg_t c;
		c = CFG_RESET;
		c.min_temp = 8'd250;
		c.max_temp = 8'd255;
		c.temp_step = 8'd10;
		c.sync_low_ticks = 20'd1;
		c.off_code = 8'd170;
		wait_idle();
		load_cfg(c, 1'b1);
		send_cmd(1'b0, 14'h1FFF);
		send_cmd(1'b0, 14'd4000);
		send_cmd(1'b1, 14'h2AAA);
	endtask

	// random settings, each carrying a batch of mostly well-formed heat commands
	task automatic test_random();
		int t;
		logic off;
		logic [13:0] raw;
		for (int p = 0; p < 9; p++) begin
			wait_idle();
			load_cfg((p == 0) ? CFG_RESET : rand_cfg(), p[0]);
			no_gaps = (p % 4 == 3);
			for (int k = 0; k < 50; k++) begin
				// let the block run dry once in the middle of a batch
				if (p == 2 && k == 25)
					wait_idle();
				case ($urandom_range(0, 9))
					0, 1: begin
						off = 1'b1;
						raw = 14'($urandom);
					end
					2: begin
						off = 1'b0;
						raw = 14'($urandom);
					end
					3: begin
						// a whole degree plus or minus just about half
						off = 1'b0;
						t = $urandom_range(0, 300) * 16 + ($urandom_range(0, 1) ? 8 : 7);
						if ($urandom_range(0, 1))
							t = -t;
						raw = t[13:0];
					end
					default: begin
						off = 1'b0;
						raw = 14'($urandom_range(0, 4800));
					end
				endcase
				send_cmd(off, raw);
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_pulse_cap();
		test_sync_cap();
		test_min_above_max();
		test_code_wrap();
		test_random();
		wait_idle();
		repeat (32) @(posedge clk);
		$display("run covered %0d commands (%0d off) under %0d register settings",
			cmds_sent, off_cmds, settings_used);
		$display("%0d waveform words checked, %0d frames cut at the item cap, %0d errors",
			words_seen, capped_frames, bad_count);
		if (bad_count == 0 && pending_words.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/pcfb_pkg.sv
rtl/pcfb_front.sv
rtl/pcfb_fifo.sv
rtl/pcfb_back.sv
rtl/pulse_count_frame_builder_unit.sv
tb/sv/tb_top.sv
